>>> hw/rtl/fse_pkg.sv
`default_nettype none
package fse_pkg;

  localparam int unsigned TAG_W      = 4;
  localparam int unsigned T_IN_W     = 16;
  localparam int unsigned TIME_W     = 21;
  localparam int unsigned MAX_JOBS_D = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [T_IN_W-1:0] arrival;
    logic [T_IN_W-1:0] service;
    logic [T_IN_W-1:0] deadline;
  } job_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    FSE_LOAD,
    FSE_DRAIN
  } fse_state_e;

endpackage
`default_nettype wire

>>> hw/rtl/fse_cell.sv
`default_nettype none
module fse_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fse_pkg::cell_ctrl_t ctrl_i,
  input  fse_pkg::job_t       new_job_i,
  input  fse_pkg::job_t       prev_job_i,
  input  wire                 prev_after_i,
  input  fse_pkg::job_t       next_job_i,
  output fse_pkg::job_t       job_o,
  output logic                after_o
);

  logic                       valid_q;
  logic [fse_pkg::TAG_W-1:0]  tag_q;
  logic [fse_pkg::T_IN_W-1:0] arrival_q;
  logic [fse_pkg::T_IN_W-1:0] service_q;
  logic [fse_pkg::T_IN_W-1:0] deadline_q;
  fse_pkg::job_t              job_q, job_d;

  assign job_q = '{valid: valid_q, tag: tag_q, arrival: arrival_q,
                   service: service_q, deadline: deadline_q};

  // Stored job stays ahead of the incoming one when it arrived no later.
  assign after_o = job_q.valid && (job_q.arrival <= new_job_i.arrival);
  assign job_o   = job_q;

  always_comb begin
    job_d = job_q;
    priority if (ctrl_i.shift) begin
      job_d = next_job_i;
    end else if (ctrl_i.insert) begin
      priority if (after_o) begin
        job_d = job_q;
      end else if (prev_after_i) begin
        job_d = new_job_i;
      end else begin
        job_d = prev_job_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= job_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q      <= job_d.tag;
    arrival_q  <= job_d.arrival;
    service_q  <= job_d.service;
    deadline_q <= job_d.deadline;
  end

endmodule
`default_nettype wire

>>> hw/rtl/fse_eval.sv
`default_nettype none
module fse_eval (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              pop_i,
  input  fse_pkg::job_t                    head_i,
  input  wire                              last_i,
  input  wire                              ovf_i,
  input  wire                              out_stall_i,
  output logic                             can_pop_o,
  output logic                             out_valid_o,
  output logic [fse_pkg::TAG_W-1:0]        out_tag_o,
  output logic [fse_pkg::TIME_W-1:0]       waiting_time_o,
  output logic [fse_pkg::TIME_W-1:0]       turnaround_time_o,
  output logic                             deadline_met_o,
  output logic                             overflow_o,
  output logic                             last_result_o
);

  logic                        valid_q, valid_d;
  logic [fse_pkg::TIME_W-1:0]  clock_q, clock_d;
  logic [fse_pkg::TIME_W-1:0]  arr_ext, start, finish, wait_t, turn_t;
  logic [fse_pkg::TIME_W:0]    sum;
  logic [fse_pkg::TAG_W-1:0]   tag_q;
  logic [fse_pkg::TIME_W-1:0]  wait_q, turn_q;
  logic                        met_q, ovf_q, last_q;

  assign can_pop_o = !valid_q || !out_stall_i;

  always_comb begin
    arr_ext = fse_pkg::TIME_W'(head_i.arrival);
    // Idle processor: start no earlier than arrival.
    start   = (clock_q > arr_ext) ? clock_q : arr_ext;
    sum     = {1'b0, start} + (fse_pkg::TIME_W + 1)'(head_i.service);
    finish  = (sum > {1'b0, fse_pkg::TIME_MAX}) ? fse_pkg::TIME_MAX
                                                : sum[fse_pkg::TIME_W-1:0];
    wait_t  = start - arr_ext;
    turn_t  = finish - arr_ext;

    valid_d = valid_q && out_stall_i;
    clock_d = clock_q;
    if (pop_i) begin
      valid_d = 1'b1;
      // Clear the clock at the end of the run.
      clock_d = last_i ? '0 : finish;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      clock_q <= '0;
    end else begin
      valid_q <= valid_d;
      clock_q <= clock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      tag_q  <= head_i.tag;
      wait_q <= wait_t;
      turn_q <= turn_t;
      met_q  <= turn_t <= fse_pkg::TIME_W'(head_i.deadline);
      ovf_q  <= ovf_i;
      last_q <= last_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_tag_o         = tag_q;
  assign waiting_time_o    = wait_q;
  assign turnaround_time_o = turn_q;
  assign deadline_met_o    = met_q;
  assign overflow_o        = ovf_q;
  assign last_result_o     = last_q;

endmodule
`default_nettype wire

>>> hw/rtl/fcfs_schedule_evaluator.sv
`default_nettype none
// FCFS schedule evaluator. Jobs enter on the input channel one per cycle and
// are placed in arrival order (equal arrivals keep load order) in a chain of
// MAX_JOBS cells; a job beyond capacity is dropped and flags overflow for the
// run. The job marked final_job (stored itself if room remains) starts the
// run: the chain then shifts one job per cycle, while the output is not
// stalled, into the scheduling stage, which emits one result per job in run
// order. The input channel stalls during the drain. Times saturate at 2097151.
module fcfs_schedule_evaluator #(
  parameter int unsigned MAX_JOBS = fse_pkg::MAX_JOBS_D
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [fse_pkg::TAG_W-1:0]    job_tag_i,
  input  wire  [fse_pkg::T_IN_W-1:0]   arrival_time_i,
  input  wire  [fse_pkg::T_IN_W-1:0]   service_time_i,
  input  wire  [fse_pkg::T_IN_W-1:0]   deadline_i,
  input  wire                          final_job_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [fse_pkg::TAG_W-1:0]    out_tag_o,
  output logic [fse_pkg::TIME_W-1:0]   waiting_time_o,
  output logic [fse_pkg::TIME_W-1:0]   turnaround_time_o,
  output logic                         deadline_met_o,
  output logic                         overflow_o,
  output logic                         last_result_o
);

  fse_pkg::fse_state_e state_q, state_d;
  logic                ovf_q, ovf_d;
  logic                run_ovf_q, run_ovf_d;
  logic                accept, full, pop, can_pop;
  fse_pkg::cell_ctrl_t ctrl;
  fse_pkg::job_t       new_job;
  fse_pkg::job_t       cells [MAX_JOBS];
  fse_pkg::job_t       prevs [MAX_JOBS];
  fse_pkg::job_t       nexts [MAX_JOBS];
  logic                after [MAX_JOBS];
  logic                prev_after [MAX_JOBS];

  assign new_job = '{valid: 1'b1, tag: job_tag_i, arrival: arrival_time_i,
                     service: service_time_i, deadline: deadline_i};

  assign in_stall_o = (state_q == fse_pkg::FSE_DRAIN);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = cells[MAX_JOBS-1].valid;
  assign pop        = (state_q == fse_pkg::FSE_DRAIN) && can_pop;
  assign ctrl       = '{insert: accept && !full, shift: pop};

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prevs[i]      = '0;
      assign prev_after[i] = 1'b1;
    end else begin : g_mid
      assign prevs[i]      = cells[i-1];
      assign prev_after[i] = after[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_end
      assign nexts[i] = '0;
    end else begin : g_next
      assign nexts[i] = cells[i+1];
    end

    fse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_job_i    (new_job),
      .prev_job_i   (prevs[i]),
      .prev_after_i (prev_after[i]),
      .next_job_i   (nexts[i]),
      .job_o        (cells[i]),
      .after_o      (after[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    ovf_d     = ovf_q;
    run_ovf_d = run_ovf_q;
    unique case (state_q)
      fse_pkg::FSE_LOAD: begin
        if (accept) begin
          if (final_job_i) begin
            run_ovf_d = ovf_q || full;
            ovf_d     = 1'b0;
            state_d   = fse_pkg::FSE_DRAIN;
          end else if (full) begin
            ovf_d = 1'b1;
          end
        end
      end
      fse_pkg::FSE_DRAIN: begin
        // Leave once the last stored job has moved to the output.
        if (pop && !nexts[0].valid) begin
          state_d = fse_pkg::FSE_LOAD;
        end
      end
      default: state_d = fse_pkg::FSE_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fse_pkg::FSE_LOAD;
      ovf_q     <= 1'b0;
      run_ovf_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovf_q     <= ovf_d;
      run_ovf_q <= run_ovf_d;
    end
  end

  fse_eval u_eval (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_i             (pop),
    .head_i            (cells[0]),
    .last_i            (!nexts[0].valid),
    .ovf_i             (run_ovf_q),
    .out_stall_i       (out_stall_i),
    .can_pop_o         (can_pop),
    .out_valid_o       (out_valid_o),
    .out_tag_o         (out_tag_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .deadline_met_o    (deadline_met_o),
    .overflow_o        (overflow_o),
    .last_result_o     (last_result_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/fse_checker.sv
`default_nettype none
module fse_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_stall_o,
  input wire                          final_job_i,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [fse_pkg::TAG_W-1:0]     out_tag_o,
  input wire [fse_pkg::TIME_W-1:0]    waiting_time_o,
  input wire [fse_pkg::TIME_W-1:0]    turnaround_time_o,
  input wire                          last_result_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_tag_o) &&
      $stable(waiting_time_o) && $stable(turnaround_time_o) &&
      $stable(last_result_o))
    else $error("stalled result changed");

  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_job_i |=> in_stall_o)
    else $error("input not stalled after final job");

  a_wait_le_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> waiting_time_o <= turnaround_time_o)
    else $error("waiting time exceeds turnaround time");

endmodule

bind fcfs_schedule_evaluator fse_checker u_fse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .final_job_i       (final_job_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_tag_o         (out_tag_o),
  .waiting_time_o    (waiting_time_o),
  .turnaround_time_o (turnaround_time_o),
  .last_result_o     (last_result_o)
);
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;

  localparam int unsigned NJOBS       = fse_pkg::MAX_JOBS_D;
  localparam int unsigned RANDOM_JOBS = 148;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    logic [fse_pkg::TAG_W-1:0]  tag;
    logic [fse_pkg::T_IN_W-1:0] arrival;
    logic [fse_pkg::T_IN_W-1:0] service;
    logic [fse_pkg::T_IN_W-1:0] deadline;
    logic                       final_job;
  } job_req_t;

  typedef struct {
    logic [fse_pkg::TAG_W-1:0]  tag;
    logic [fse_pkg::TIME_W-1:0] waiting;
    logic [fse_pkg::TIME_W-1:0] turnaround;
    logic                       met;
    logic                       ovf;
    logic                       last_res;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [fse_pkg::TAG_W-1:0]  job_tag_i = '0;
  logic [fse_pkg::T_IN_W-1:0] arrival_time_i = '0;
  logic [fse_pkg::T_IN_W-1:0] service_time_i = '0;
  logic [fse_pkg::T_IN_W-1:0] deadline_i = '0;
  logic                       final_job_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [fse_pkg::TAG_W-1:0]  out_tag_o;
  logic [fse_pkg::TIME_W-1:0] waiting_time_o;
  logic [fse_pkg::TIME_W-1:0] turnaround_time_o;
  logic                       deadline_met_o;
  logic                       overflow_o;
  logic                       last_result_o;

  fcfs_schedule_evaluator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .job_tag_i         (job_tag_i),
    .arrival_time_i    (arrival_time_i),
    .service_time_i    (service_time_i),
    .deadline_i        (deadline_i),
    .final_job_i       (final_job_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_tag_o         (out_tag_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .deadline_met_o    (deadline_met_o),
    .overflow_o        (overflow_o),
    .last_result_o     (last_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  job_req_t   job_queue[$];
  sched_res_t sched_expected[$];
  job_req_t   cur_job;

  // scoreboard copy of the job store
  logic [fse_pkg::T_IN_W-1:0] held_arrival[NJOBS];
  logic [fse_pkg::T_IN_W-1:0] held_service[NJOBS];
  logic [fse_pkg::T_IN_W-1:0] held_deadline[NJOBS];
  logic [fse_pkg::TAG_W-1:0]  held_tag[NJOBS];
  int unsigned                held_cnt = 0;
  logic                       held_ovf = 1'b0;

  int unsigned total_jobs = 0;
  int unsigned random_jobs = 0;
  int unsigned jobs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned runs_done = 0;
  int unsigned ovf_runs = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;

  int unsigned in_gap, in_calm, stall_left, out_calm;

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Store one request; on the final one, order by arrival (stable) and run FCFS.
  task automatic schedule_job(input job_req_t j);
    int unsigned order[NJOBS];
    int unsigned n, i, k, cur, now, arr, start, finish;
    sched_res_t  r;
    if (held_cnt < NJOBS) begin
      held_arrival[held_cnt]  = j.arrival;
      held_service[held_cnt]  = j.service;
      held_deadline[held_cnt] = j.deadline;
      held_tag[held_cnt]      = j.tag;
      held_cnt++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!j.final_job) return;
    n = held_cnt;
    for (i = 0; i < n; i++) begin
      cur = i;
      k = i;
      while (k > 0 && held_arrival[order[k-1]] > held_arrival[cur]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = cur;
    end
    now = 0;
    for (i = 0; i < n; i++) begin
      arr    = 32'(held_arrival[order[i]]);
      start  = (now > arr) ? now : arr;
      finish = start + 32'(held_service[order[i]]);
      if (finish > 32'(fse_pkg::TIME_MAX)) finish = 32'(fse_pkg::TIME_MAX);
      now = finish;
      r.tag        = held_tag[order[i]];
      r.waiting    = fse_pkg::TIME_W'(start - arr);
      r.turnaround = fse_pkg::TIME_W'(finish - arr);
      r.met        = (finish - arr) <= 32'(held_deadline[order[i]]);
      r.ovf        = held_ovf;
      r.last_res   = (i + 1 == n);
      sched_expected.push_back(r);
    end
    runs_done++;
    if (held_ovf) ovf_runs++;
    held_cnt = 0;
    held_ovf = 1'b0;
  endtask

  task automatic push_job(input logic [fse_pkg::TAG_W-1:0] tag,
                          input logic [fse_pkg::T_IN_W-1:0] arr,
                          input logic [fse_pkg::T_IN_W-1:0] svc,
                          input logic [fse_pkg::T_IN_W-1:0] dl,
                          input logic fin);
    job_req_t j;
    j.tag       = tag;
    j.arrival   = arr;
    j.service   = svc;
    j.deadline  = dl;
    j.final_job = fin;
    job_queue.push_back(j);
  endtask

  task automatic add_random_set();
    int unsigned n, amode, smode, base, i;
    logic [fse_pkg::T_IN_W-1:0] arr, svc, dl;
    if ($urandom_range(0, 99) < 85) n = $urandom_range(1, NJOBS);
    else n = $urandom_range(NJOBS + 1, NJOBS + 4);
    amode = $urandom_range(0, 2);
    smode = $urandom_range(0, 1);
    base  = $urandom_range(0, 65535 - 64);
    for (i = 0; i < n; i++) begin
      case (amode)
        0: arr = fse_pkg::T_IN_W'($urandom_range(0, 65535));
        1: arr = fse_pkg::T_IN_W'($urandom_range(0, 31));
        default: arr = fse_pkg::T_IN_W'(base + $urandom_range(0, 63));
      endcase
      svc = (smode != 0) ? fse_pkg::T_IN_W'($urandom_range(0, 65535))
                         : fse_pkg::T_IN_W'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
        0: dl = fse_pkg::T_IN_W'($urandom_range(0, 65535));
        1: dl = fse_pkg::T_IN_W'($urandom_range(0, 15));
        2: dl = fse_pkg::T_IN_W'($urandom_range(0, 511));
        default: dl = 16'hFFFF;
      endcase
      push_job(fse_pkg::TAG_W'($urandom_range(0, 15)), arr, svc, dl, i == n - 1);
    end
    random_jobs += n;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
      in_calm    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        schedule_job(cur_job);
        jobs_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (job_queue.size() != 0) begin
          cur_job = job_queue.pop_front();
          job_tag_i      <= cur_job.tag;
          arrival_time_i <= cur_job.arrival;
          service_time_i <= cur_job.service;
          deadline_i     <= cur_job.deadline;
          final_job_i    <= cur_job.final_job;
          in_valid_i     <= 1'b1;
          if (in_calm != 0) begin
            in_calm <= in_calm - 1;
            in_gap  <= 0;
          end else begin
            in_gap <= pick_pause();
            if ($urandom_range(0, 29) == 0) in_calm <= $urandom_range(20, 60);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      out_calm    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (sched_expected.size() == 0) begin
          $error("unexpected result: tag %0d", out_tag_o);
          mismatch_cnt++;
        end else begin
          want = sched_expected.pop_front();
          check_field("out_tag", want.tag, out_tag_o);
          check_field("waiting_time", want.waiting, waiting_time_o);
          check_field("turnaround_time", want.turnaround, turnaround_time_o);
          check_field("deadline_met", want.met, deadline_met_o);
          check_field("overflow", want.ovf, overflow_o);
          check_field("last_result", want.last_res, last_result_o);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (out_calm != 0) begin
          out_calm   <= out_calm - 1;
          stall_left <= 0;
        end else begin
          stall_left <= pick_pause();
          if ($urandom_range(0, 29) == 0) out_calm <= $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: timeout, %0d of %0d requests accepted", jobs_sent, total_jobs);
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    // single job at the top of every field
    push_job(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // equal arrivals keep load order, a zero job, an idle gap before the last
    push_job(4'h0, 16'd100, 16'd10, 16'd5, 1'b0);
    push_job(4'h1, 16'd100, 16'd20, 16'hFFFF, 1'b0);
    push_job(4'h2, 16'd0, 16'd0, 16'd0, 1'b0);
    push_job(4'h3, 16'd5000, 16'd1, 16'd0, 1'b1);
    // one request past capacity; the dropped final one still starts the run
    for (i = 0; i <= NJOBS; i++)
      push_job(i[3:0], fse_pkg::T_IN_W'(65535 - i * 4000),
               fse_pkg::T_IN_W'(3000 + i * 17),
               fse_pkg::T_IN_W'(9000 * i[3:0]), i == NJOBS);
    while (random_jobs < RANDOM_JOBS) add_random_set();
    total_jobs = job_queue.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (jobs_sent != total_jobs || sched_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("tb: %0d requests in %0d runs, %0d runs dropped requests for lack of room",
             total_jobs, runs_done, ovf_runs);
    $display("tb: %0d results compared, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
